// ===== src/rfst_pkg.sv =====
// shared types, constants and fixed-point helpers of the rotating frame source block
`default_nettype none

package rfst_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned UQ_W         = 31;
  localparam int unsigned PROD_W       = 2 * DATA_W;
  localparam int unsigned D_W          = DATA_W + 2;
  localparam int unsigned WIDE_W       = 72;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CROSS_STAGES = 3;
  localparam int unsigned APPLY_STAGES = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_DENSITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_Z     = 3'd4;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic [UQ_W-1:0]          uq_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef q_t                       vec3_t [3];

  typedef enum logic [1:0] {
    MODE_CORIOLIS = 2'd0,
    MODE_MOMENTUM = 2'd1,
    MODE_ENERGY   = 2'd2,
    MODE_PASS     = 2'd3
  } term_mode_e;

  typedef struct packed {
    q_t   val;
    logic sat;
  } clamp_t;

  localparam wide_t Q_MAX = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t Q_MIN = wide_t'(signed'({1'b1, {(DATA_W-1){1'b0}}}));

  // round to nearest, ties away from zero
  function automatic wide_t round_q(wide_t p, int unsigned frac);
    wide_t half;
    wide_t adj;
    half = wide_t'(1) <<< (frac - 1);
    adj = '0;
    adj[0] = p[WIDE_W-1];
    return (p + half - adj) >>> frac;
  endfunction

  function automatic clamp_t clamp_q(wide_t v);
    clamp_t r;
    if (v > Q_MAX) begin
      r.val = Q_MAX[DATA_W-1:0];
      r.sat = 1'b1;
    end else if (v < Q_MIN) begin
      r.val = Q_MIN[DATA_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/rotating_frame_source_term_top.sv =====
// top level of the rotating frame coriolis and centrifugal source term pipeline
// The block accepts one cell per clock: busy_o stays low and a request taken
// with start_i returns its updated source on the result ports, marked by a
// one-cycle done_o. The path runs through an input register, two levels of
// three-stage cross product units (omega x w and omega x c in parallel, then
// omega x (omega x c)) and the six-stage assembly unit with its second multiply
// for the energy term. Results come out in request order and cannot be held
// off. Configuration registers may only be written while no request is in
// flight.
`default_nettype none

module rotating_frame_source_term_top #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  input  logic                                  cfg_we_i,
  input  logic [rfst_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rfst_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  logic [INDEX_BITS-1:0]                 cell_index_i,
  input  logic [rfst_pkg::UQ_W-1:0]             cell_volume_i,
  input  logic [rfst_pkg::UQ_W-1:0]             density_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    vel_x_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    vel_y_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    vel_z_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    pos_x_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    pos_y_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    pos_z_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    src_x_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    src_y_i,
  input  logic signed [rfst_pkg::DATA_W-1:0]    src_z_i,
  output logic [INDEX_BITS-1:0]                 out_index_o,
  output logic signed [rfst_pkg::DATA_W-1:0]    new_src_x_o,
  output logic signed [rfst_pkg::DATA_W-1:0]    new_src_y_o,
  output logic signed [rfst_pkg::DATA_W-1:0]    new_src_z_o,
  output logic                                  saturated_o
);
  import rfst_pkg::*;

  localparam int unsigned LATENCY = 1 + 2 * CROSS_STAGES + APPLY_STAGES;
  localparam int unsigned W_DLY   = 2 * CROSS_STAGES;

  term_mode_e term_mode_q;
  logic       use_density_q;
  q_t         omega_x_q;
  q_t         omega_y_q;
  q_t         omega_z_q;
  vec3_t      omega;

  logic [LATENCY-1:0]    valid_q;
  logic [INDEX_BITS-1:0] idx_q [LATENCY];

  uq_t   vol0_q;
  uq_t   rho0_q;
  vec3_t w0_q;
  vec3_t c0_q;
  vec3_t src0_q;

  vec3_t w_dly_q   [W_DLY];
  vec3_t src_dly_q [W_DLY];
  vec3_t ow_dly_q  [CROSS_STAGES];
  uq_t   s_dly_q   [CROSS_STAGES];
  logic [CROSS_STAGES-1:0] sat_dly_q;

  vec3_t ow;
  vec3_t oc;
  vec3_t ooc;
  vec3_t res;
  uq_t   s;
  logic  ow_sat;
  logic  oc_sat;
  logic  s_sat;
  logic  ooc_sat;
  logic  res_sat;

  assign omega[0] = omega_x_q;
  assign omega[1] = omega_y_q;
  assign omega[2] = omega_z_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_mode_q   <= MODE_MOMENTUM;
      use_density_q <= 1'b0;
      omega_x_q     <= '0;
      omega_y_q     <= '0;
      omega_z_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TERM_MODE:   term_mode_q   <= term_mode_e'(cfg_wdata_i[1:0]);
        CFG_USE_DENSITY: use_density_q <= cfg_wdata_i[0];
        CFG_OMEGA_X:     omega_x_q     <= q_t'(cfg_wdata_i);
        CFG_OMEGA_Y:     omega_y_q     <= q_t'(cfg_wdata_i);
        CFG_OMEGA_Z:     omega_z_q     <= q_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LATENCY-2:0], start_i & ~busy_o};
    end
  end

  // request payload and alignment delays
  always_ff @(posedge clk_i) begin
    idx_q[0] <= cell_index_i;
    for (int k = 1; k < LATENCY; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
    vol0_q    <= cell_volume_i;
    rho0_q    <= density_i;
    w0_q[0]   <= vel_x_i;
    w0_q[1]   <= vel_y_i;
    w0_q[2]   <= vel_z_i;
    c0_q[0]   <= pos_x_i;
    c0_q[1]   <= pos_y_i;
    c0_q[2]   <= pos_z_i;
    src0_q[0] <= src_x_i;
    src0_q[1] <= src_y_i;
    src0_q[2] <= src_z_i;
    w_dly_q[0]   <= w0_q;
    src_dly_q[0] <= src0_q;
    for (int k = 1; k < W_DLY; k++) begin
      w_dly_q[k]   <= w_dly_q[k-1];
      src_dly_q[k] <= src_dly_q[k-1];
    end
    ow_dly_q[0] <= ow;
    s_dly_q[0]  <= s;
    for (int k = 1; k < CROSS_STAGES; k++) begin
      ow_dly_q[k] <= ow_dly_q[k-1];
      s_dly_q[k]  <= s_dly_q[k-1];
    end
    sat_dly_q <= {sat_dly_q[CROSS_STAGES-2:0], ow_sat | oc_sat | s_sat};
  end

  rfst_cross #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cross_w (
    .clk_i(clk_i),
    .a_i  (omega),
    .b_i  (w0_q),
    .r_o  (ow),
    .sat_o(ow_sat)
  );

  rfst_cross #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cross_c (
    .clk_i(clk_i),
    .a_i  (omega),
    .b_i  (c0_q),
    .r_o  (oc),
    .sat_o(oc_sat)
  );

  rfst_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .use_density_i(use_density_q),
    .vol_i        (vol0_q),
    .rho_i        (rho0_q),
    .s_o          (s),
    .sat_o        (s_sat)
  );

  rfst_cross #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cross_oc (
    .clk_i(clk_i),
    .a_i  (omega),
    .b_i  (oc),
    .r_o  (ooc),
    .sat_o(ooc_sat)
  );

  rfst_apply #(
    .FRAC_BITS(FRAC_BITS)
  ) u_apply (
    .clk_i (clk_i),
    .mode_i(term_mode_q),
    .s_i   (s_dly_q[CROSS_STAGES-1]),
    .ow_i  (ow_dly_q[CROSS_STAGES-1]),
    .ooc_i (ooc),
    .w_i   (w_dly_q[W_DLY-1]),
    .src_i (src_dly_q[W_DLY-1]),
    .sat_i (sat_dly_q[CROSS_STAGES-1] | ooc_sat),
    .res_o (res),
    .sat_o (res_sat)
  );

  assign busy_o      = 1'b0;
  assign done_o      = valid_q[LATENCY-1];
  assign out_index_o = idx_q[LATENCY-1];
  assign new_src_x_o = res[0];
  assign new_src_y_o = res[1];
  assign new_src_z_o = res[2];
  assign saturated_o = res_sat;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("request did not complete after the pipeline latency");

  a_index_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_index_o == $past(cell_index_i, LATENCY))
    else $error("result index does not match its request");

  a_pass_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && term_mode_q == MODE_PASS |->
      !saturated_o && new_src_x_o == $past(src_x_i, LATENCY))
    else $error("unused mode altered the source");

  a_energy_yz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && term_mode_q == MODE_ENERGY |->
      new_src_y_o == $past(src_y_i, LATENCY) && new_src_z_o == $past(src_z_i, LATENCY))
    else $error("energy mode altered the y or z source");

endmodule

`default_nettype wire

// ===== src/rfst_cross.sv =====
// three-stage fixed-point cross product: multiply, round, subtract and clamp
`default_nettype none

module rfst_cross #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  rfst_pkg::vec3_t a_i,
  input  rfst_pkg::vec3_t b_i,
  output rfst_pkg::vec3_t r_o,
  output logic            sat_o
);
  import rfst_pkg::*;

  logic [2:0] lane_sat;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    prod_t  lhs_q;
    prod_t  rhs_q;
    wide_t  lhs_rnd_q;
    wide_t  rhs_rnd_q;
    q_t     r_q;
    logic   sat_q;
    clamp_t res;

    always_comb res = clamp_q(lhs_rnd_q - rhs_rnd_q);

    always_ff @(posedge clk_i) begin
      lhs_q     <= a_i[J] * b_i[K];
      rhs_q     <= a_i[K] * b_i[J];
      lhs_rnd_q <= round_q(wide_t'(lhs_q), FRAC_BITS);
      rhs_rnd_q <= round_q(wide_t'(rhs_q), FRAC_BITS);
      r_q       <= res.val;
      sat_q     <= res.sat;
    end

    assign r_o[i]      = r_q;
    assign lane_sat[i] = sat_q;
  end

  assign sat_o = |lane_sat;

endmodule

`default_nettype wire

// ===== src/rfst_scale.sv =====
// three-stage cell scale: volume times optional density, rounded and clamped
`default_nettype none

module rfst_scale #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          use_density_i,
  input  rfst_pkg::uq_t vol_i,
  input  rfst_pkg::uq_t rho_i,
  output rfst_pkg::uq_t s_o,
  output logic          sat_o
);
  import rfst_pkg::*;

  localparam int unsigned UPROD_W = 2 * UQ_W;

  logic [UPROD_W-1:0] prod_q;
  logic [UPROD_W-1:0] rnd_q;
  uq_t                vol1_q;
  uq_t                vol2_q;
  uq_t                s_q;
  logic               sat_q;
  logic               over;

  assign over = |rnd_q[UPROD_W-1:UQ_W];

  always_ff @(posedge clk_i) begin
    prod_q <= vol_i * rho_i;
    vol1_q <= vol_i;
    rnd_q  <= (prod_q + (UPROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    vol2_q <= vol1_q;
    if (!use_density_i) begin
      s_q <= vol2_q;
    end else if (over) begin
      s_q <= '1;
    end else begin
      s_q <= rnd_q[UQ_W-1:0];
    end
    sat_q <= use_density_i & over;
  end

  assign s_o   = s_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// ===== src/rfst_apply.sv =====
// six-stage term assembly: coriolis and centrifugal terms, energy dot product, final update
`default_nettype none

module rfst_apply #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  rfst_pkg::term_mode_e mode_i,
  input  rfst_pkg::uq_t        s_i,
  input  rfst_pkg::vec3_t      ow_i,
  input  rfst_pkg::vec3_t      ooc_i,
  input  rfst_pkg::vec3_t      w_i,
  input  rfst_pkg::vec3_t      src_i,
  input  logic                 sat_i,
  output rfst_pkg::vec3_t      res_o,
  output logic                 sat_o
);
  import rfst_pkg::*;

  localparam int unsigned M_W   = DATA_W + D_W;
  localparam int unsigned CARRY = APPLY_STAGES - 1;

  typedef logic signed [D_W-1:0] d_t;
  typedef logic signed [M_W-1:0] m_t;

  d_t               d_q   [3];
  prod_t            e_q   [3];
  m_t               m_q   [3];
  wide_t            er_q  [3];
  wide_t            mr_q  [3][3];
  q_t               sx_q  [3];
  q_t               dot_q;
  logic [2:0]       dsat_q;
  prod_t            pe_q;
  wide_t            per_q;
  vec3_t            src_q [CARRY];
  logic [CARRY-1:0] sat_q;
  vec3_t            res_q;
  logic             out_sat_q;

  wide_t  dot_sum;
  clamp_t dot_c;
  clamp_t upd   [3];
  clamp_t upd_e;
  vec3_t  res_d;
  logic   sat_d;

  always_comb begin
    dot_sum = er_q[0] + er_q[1] + er_q[2];
    dot_c   = clamp_q(dot_sum);
  end

  always_comb begin
    res_d = src_q[CARRY-1];
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      upd[i] = clamp_q(wide_t'(src_q[CARRY-1][i]) - mr_q[2][i]);
    end
    upd_e = clamp_q(wide_t'(src_q[CARRY-1][0]) - per_q);
    case (mode_i)
      MODE_CORIOLIS, MODE_MOMENTUM: begin
        for (int i = 0; i < 3; i++) begin
          res_d[i] = upd[i].val;
        end
        sat_d = sat_q[CARRY-1] | upd[0].sat | upd[1].sat | upd[2].sat;
      end
      MODE_ENERGY: begin
        res_d[0] = upd_e.val;
        sat_d    = sat_q[CARRY-1] | dsat_q[2] | upd_e.sat;
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]     <= (d_t'(ow_i[i]) <<< 1)
                    + ((mode_i == MODE_MOMENTUM) ? d_t'(ooc_i[i]) : d_t'(0));
      e_q[i]     <= ooc_i[i] * w_i[i];
      m_q[i]     <= sx_q[0] * d_q[i];
      er_q[i]    <= round_q(wide_t'(e_q[i]), FRAC_BITS);
      mr_q[0][i] <= round_q(wide_t'(m_q[i]), FRAC_BITS);
      mr_q[1][i] <= mr_q[0][i];
      mr_q[2][i] <= mr_q[1][i];
    end
    sx_q[0] <= q_t'({1'b0, s_i});
    sx_q[1] <= sx_q[0];
    sx_q[2] <= sx_q[1];
    dot_q   <= dot_c.val;
    dsat_q  <= {dsat_q[1:0], dot_c.sat};
    pe_q    <= sx_q[2] * dot_q;
    per_q   <= round_q(wide_t'(pe_q), FRAC_BITS);
    src_q[0] <= src_i;
    for (int k = 1; k < CARRY; k++) begin
      src_q[k] <= src_q[k-1];
    end
    sat_q     <= {sat_q[CARRY-2:0], sat_i};
    res_q     <= res_d;
    out_sat_q <= sat_d;
  end

  assign res_o = res_q;
  assign sat_o = out_sat_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench of the rotating frame coriolis and centrifugal source block
`timescale 1ns / 1ps

module tb_top;
  import rfst_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned INDEX_BITS  = 20;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          CFG_TOP     = (1 << CFG_IDX_W) - 1;

  localparam q_t     HI_Q  = 32'sh7FFF_FFFF;
  localparam q_t     LO_Q  = 32'sh8000_0000;
  localparam uq_t    UQ_HI = '1;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  // directed rotation rate: 1.5, -2.25, 0.75
  localparam q_t DIR_OX = 32'sh0001_8000;
  localparam q_t DIR_OY = -32'sh0002_4000;
  localparam q_t DIR_OZ = 32'sh0000_C000;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    uq_t                   vol;
    uq_t                   rho;
    q_t                    vx, vy, vz;
    q_t                    px, py, pz;
    q_t                    sx, sy, sz;
  } cell_req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    q_t                    x, y, z;
    logic                  sat;
  } src_update_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [DATA_W-1:0]     cfg_wdata_i = '0;
  cell_req_t             cell_q      = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [INDEX_BITS-1:0] out_index_o;
  q_t                    new_src_x_o;
  q_t                    new_src_y_o;
  q_t                    new_src_z_o;
  logic                  saturated_o;

  term_mode_e  mode_cfg   = MODE_MOMENTUM;
  bit          density_on = 1'b0;
  longint      omega_cfg [3] = '{0, 0, 0};

  cell_req_t   pending_cells [$];
  src_update_t predicted_updates [$];
  int          gap_max      = 0;
  int          gap_left     = 0;
  int          err_count    = 0;
  int          quiet_cycles = 0;
  src_update_t next_update;
  src_update_t want;

  always #2 clk_i = ~clk_i;

  rotating_frame_source_term_top #(
    .FRAC_BITS (FRAC_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cell_index_i (cell_q.idx),
    .cell_volume_i(cell_q.vol),
    .density_i    (cell_q.rho),
    .vel_x_i      (cell_q.vx),
    .vel_y_i      (cell_q.vy),
    .vel_z_i      (cell_q.vz),
    .pos_x_i      (cell_q.px),
    .pos_y_i      (cell_q.py),
    .pos_z_i      (cell_q.pz),
    .src_x_i      (cell_q.sx),
    .src_y_i      (cell_q.sy),
    .src_z_i      (cell_q.sz),
    .out_index_o  (out_index_o),
    .new_src_x_o  (new_src_x_o),
    .new_src_y_o  (new_src_y_o),
    .new_src_z_o  (new_src_z_o),
    .saturated_o  (saturated_o)
  );

  // fixed-point product, rounded to nearest with ties away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    bit [63:0] ma;
    bit [63:0] mb;
    bit [63:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ma * mb;
    p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  task automatic clip_into(input longint v, output longint r, inout bit hit);
    if (v > S32_HI) begin
      r = S32_HI;
      hit = 1'b1;
    end else if (v < S32_LO) begin
      r = S32_LO;
      hit = 1'b1;
    end else begin
      r = v;
    end
  endtask

  task automatic compute_new_source(input cell_req_t r, output src_update_t u);
    longint om [3];
    longint w [3];
    longint c [3];
    longint src [3];
    longint ow [3];
    longint oc [3];
    longint ooc [3];
    longint res [3];
    longint s;
    longint d;
    longint dot;
    bit     hit;
    int     j;
    int     k;
    om  = omega_cfg;
    w   = '{longint'(r.vx), longint'(r.vy), longint'(r.vz)};
    c   = '{longint'(r.px), longint'(r.py), longint'(r.pz)};
    src = '{longint'(r.sx), longint'(r.sy), longint'(r.sz)};
    hit = 1'b0;
    if (density_on)
      clip_into(fx_mul(longint'(r.vol), longint'(r.rho)), s, hit);
    else
      s = longint'(r.vol);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      clip_into(fx_mul(om[j], w[k]) - fx_mul(om[k], w[j]), ow[i], hit);
      clip_into(fx_mul(om[j], c[k]) - fx_mul(om[k], c[j]), oc[i], hit);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      clip_into(fx_mul(om[j], oc[k]) - fx_mul(om[k], oc[j]), ooc[i], hit);
      res[i] = src[i];
    end
    case (mode_cfg)
      MODE_CORIOLIS, MODE_MOMENTUM: begin
        for (int i = 0; i < 3; i++) begin
          d = 2 * ow[i];
          if (mode_cfg == MODE_MOMENTUM)
            d += ooc[i];
          clip_into(src[i] - fx_mul(s, d), res[i], hit);
        end
      end
      MODE_ENERGY: begin
        dot = fx_mul(ooc[0], w[0]) + fx_mul(ooc[1], w[1]) + fx_mul(ooc[2], w[2]);
        clip_into(dot, dot, hit);
        clip_into(src[0] - fx_mul(s, dot), res[0], hit);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    u.idx = r.idx;
    u.x   = res[0][DATA_W-1:0];
    u.y   = res[1][DATA_W-1:0];
    u.z   = res[2][DATA_W-1:0];
    u.sat = hit;
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(0, 11))
      0: return HI_Q;
      1: return LO_Q;
      2: return '0;
      default: return q_t'($signed($urandom) >>> $urandom_range(0, 28));
    endcase
  endfunction

  function automatic uq_t rand_uq();
    case ($urandom_range(0, 9))
      0: return UQ_HI;
      1: return '0;
      default: return uq_t'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  function automatic q_t rand_omega();
    case ($urandom_range(0, 9))
      0: return HI_Q;
      1: return LO_Q;
      2: return '0;
      default: return q_t'($signed($urandom) >>> $urandom_range(6, 22));
    endcase
  endfunction

  function automatic cell_req_t rand_cell();
    cell_req_t r;
    r.idx = INDEX_BITS'($urandom);
    r.vol = rand_uq();
    r.rho = rand_uq();
    r.vx  = rand_q();
    r.vy  = rand_q();
    r.vz  = rand_q();
    r.px  = rand_q();
    r.py  = rand_q();
    r.pz  = rand_q();
    r.sx  = rand_q();
    r.sy  = rand_q();
    r.sz  = rand_q();
    return r;
  endfunction

  function automatic cell_req_t fill_cell(input q_t sv, input uq_t uv,
                                          input logic [INDEX_BITS-1:0] ix);
    cell_req_t r;
    r.idx = ix;
    r.vol = uv;
    r.rho = uv;
    r.vx  = sv;
    r.vy  = sv;
    r.vz  = sv;
    r.px  = sv;
    r.py  = sv;
    r.pz  = sv;
    r.sx  = sv;
    r.sy  = sv;
    r.sz  = sv;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TERM_MODE:   mode_cfg = term_mode_e'(val[1:0]);
      CFG_USE_DENSITY: density_on = val[0];
      CFG_OMEGA_X:     omega_cfg[0] = longint'($signed(val));
      CFG_OMEGA_Y:     omega_cfg[1] = longint'($signed(val));
      CFG_OMEGA_Z:     omega_cfg[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_config(input term_mode_e m, input bit dens,
                            input q_t ox, input q_t oy, input q_t oz);
    write_reg(CFG_TERM_MODE, {30'($urandom), m});
    write_reg(CFG_USE_DENSITY, {31'($urandom), dens});
    write_reg(CFG_OMEGA_X, ox);
    write_reg(CFG_OMEGA_Y, oy);
    write_reg(CFG_OMEGA_Z, oz);
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_OMEGA_Z) + 1, CFG_TOP)), $urandom);
  endtask

  // checked away from the rising edge so the driver and monitor have settled
  task automatic drain();
    while (pending_cells.size() != 0 || start_i || predicted_updates.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        compute_new_source(cell_q, next_update);
        predicted_updates.push_back(next_update);
      end
      if (!(start_i && busy_o)) begin
        if (gap_left != 0) begin
          start_i  <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_cells.size() != 0) begin
          cell_q   <= pending_cells.pop_front();
          start_i  <= 1'b1;
          gap_left <= $urandom_range(0, gap_max);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (predicted_updates.size() == 0) begin
        err_count++;
        $display("%0t: result for cell %0h with no request outstanding", $time, out_index_o);
      end else begin
        want = predicted_updates.pop_front();
        check_field("out_index", DATA_W'(want.idx), DATA_W'(out_index_o));
        check_field("new_src_x", want.x, new_src_x_o);
        check_field("new_src_y", want.y, new_src_y_o);
        check_field("new_src_z", want.z, new_src_z_o);
        check_field("saturated", DATA_W'(want.sat), DATA_W'(saturated_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: momentum mode, no density, zero rotation
    pending_cells.push_back(fill_cell(HI_Q, UQ_HI, '1));
    pending_cells.push_back(rand_cell());
    drain();

    for (int m = 0; m < 4; m++) begin
      set_config(term_mode_e'(m), (m == 1 || m == 2), DIR_OX, DIR_OY, DIR_OZ);
      gap_max = 3 * m;
      pending_cells.push_back(fill_cell(HI_Q, UQ_HI, '1));
      pending_cells.push_back(fill_cell(LO_Q, '0, '0));
      pending_cells.push_back(fill_cell('0, UQ_HI, '0));
      pending_cells.push_back(rand_cell());
      drain();
    end

    // extreme rotation rates, with writes to an unused index before and after the configuration
    write_unused_reg();
    set_config(MODE_MOMENTUM, 1'b1, HI_Q, LO_Q, HI_Q);
    write_unused_reg();
    pending_cells.push_back(fill_cell(HI_Q, UQ_HI, '1));
    pending_cells.push_back(fill_cell(LO_Q, UQ_HI, '0));
    pending_cells.push_back(rand_cell());
    drain();
    set_config(MODE_ENERGY, 1'b1, LO_Q, LO_Q, LO_Q);
    pending_cells.push_back(fill_cell(HI_Q, UQ_HI, '1));
    pending_cells.push_back(fill_cell(LO_Q, UQ_HI, '0));
    drain();

    repeat (14) begin
      set_config(term_mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 rand_omega(), rand_omega(), rand_omega());
      if ($urandom_range(0, 3) == 0)
        write_unused_reg();
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 15;
      endcase
      repeat (120) pending_cells.push_back(rand_cell());
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (err_count == 0 && predicted_updates.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
